// File: rtl/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared types, micro-op codes and the control store for the gcd/lcm unit.
// ----------------------------------------------------------------------------
package gcl_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int FIELD_W           = 16;
	localparam int GCD_W             = 16;
	localparam int LCM_W             = 32;
	localparam int UPC_W             = 4;

	typedef struct packed {
		logic [FIELD_W-1:0] first_operand;
		logic [FIELD_W-1:0] second_operand;
	} gcl_in_t;

	typedef struct packed {
		logic [GCD_W-1:0] gcd_value;
		logic [LCM_W-1:0] lcm_value;
	} gcl_out_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_STRIP,
		OP_REDUCE,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_MUL,
		OP_ZERO,
		OP_EMIT
	} gcl_uop_t;

	typedef enum logic [2:0] {
		CND_ALWAYS,
		CND_IN_TAKE,
		CND_ANY_ZERO,
		CND_BOTH_EVEN,
		CND_NOT_EQUAL,
		CND_CNT_MORE,
		CND_OUT_FREE
	} gcl_cond_t;

	typedef struct packed {
		gcl_uop_t         op;
		gcl_cond_t        cond;
		logic             hold;
		logic [UPC_W-1:0] target;
	} gcl_uword_t;

	typedef struct packed {
		logic any_zero;
		logic both_even;
		logic not_equal;
		logic cnt_more;
	} gcl_flags_t;

	localparam logic [UPC_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [UPC_W-1:0] ST_CHECK  = 4'd1;
	localparam logic [UPC_W-1:0] ST_STRIP  = 4'd2;
	localparam logic [UPC_W-1:0] ST_REDUCE = 4'd3;
	localparam logic [UPC_W-1:0] ST_DIVINI = 4'd4;
	localparam logic [UPC_W-1:0] ST_DIVSTP = 4'd5;
	localparam logic [UPC_W-1:0] ST_MUL    = 4'd6;
	localparam logic [UPC_W-1:0] ST_ZERO   = 4'd7;
	localparam logic [UPC_W-1:0] ST_EMIT   = 4'd8;
	localparam logic [UPC_W-1:0] ST_LAST   = ST_EMIT;

	// jump to target when cond holds; otherwise stay (hold) or advance
	function automatic gcl_uword_t gcl_rom(input logic [UPC_W-1:0] pc);
		gcl_uword_t w;
		unique case (pc)
			ST_IDLE:   w = '{op: OP_LOAD,    cond: CND_IN_TAKE,   hold: 1'b1, target: ST_CHECK};
			ST_CHECK:  w = '{op: OP_NOP,     cond: CND_ANY_ZERO,  hold: 1'b0, target: ST_ZERO};
			ST_STRIP:  w = '{op: OP_STRIP,   cond: CND_BOTH_EVEN, hold: 1'b0, target: ST_STRIP};
			ST_REDUCE: w = '{op: OP_REDUCE,  cond: CND_NOT_EQUAL, hold: 1'b0, target: ST_REDUCE};
			ST_DIVINI: w = '{op: OP_DIVINIT, cond: CND_ALWAYS,    hold: 1'b0, target: ST_DIVSTP};
			ST_DIVSTP: w = '{op: OP_DIVSTEP, cond: CND_CNT_MORE,  hold: 1'b0, target: ST_DIVSTP};
			ST_MUL:    w = '{op: OP_MUL,     cond: CND_ALWAYS,    hold: 1'b0, target: ST_EMIT};
			ST_ZERO:   w = '{op: OP_ZERO,    cond: CND_ALWAYS,    hold: 1'b0, target: ST_EMIT};
			ST_EMIT:   w = '{op: OP_EMIT,    cond: CND_OUT_FREE,  hold: 1'b1, target: ST_IDLE};
			default:   w = '{op: OP_NOP,     cond: CND_ALWAYS,    hold: 1'b0, target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of an operand pair.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word with gcd and lcm = (a / gcd) * b;
// a zero operand gives gcd 1 and lcm 0. Only the low OPERAND_WIDTH bits of the
// operands are used (at most 16). A small microprogram drives one datapath
// and the block works on one pair at a time. The binary gcd loop (one shift
// or subtract per cycle, data dependent) and the N-step restoring divider,
// with N = min(OPERAND_WIDTH, 16), set how long a pair takes; a result also
// waits while the previous result word is still stalled. A zero operand
// skips both loops and goes from the check straight to the zero step. The
// next pair is taken once the result sits in the output register, even while
// that word is stalled.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
	parameter int OPERAND_WIDTH = gcl_pkg::OPERAND_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              opnd_valid,
	output logic              opnd_stall,
	input  gcl_pkg::gcl_in_t  opnd,
	output logic              res_valid,
	input  logic              res_stall,
	output gcl_pkg::gcl_out_t res
);
	import gcl_pkg::*;

	gcl_uop_t             op;
	gcl_flags_t           flags;
	logic                 take;
	logic                 out_free;
	logic                 emit;
	logic [GCD_W-1:0]     gcd_value;
	logic [LCM_W-1:0]     lcm_value;
	logic                 res_valid_q;
	gcl_out_t             res_q;

	assign opnd_stall = (op != OP_LOAD);
	assign take       = opnd_valid && !opnd_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign emit       = (op == OP_EMIT) && out_free;

	gcl_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags    (flags),
		.in_take  (take),
		.out_free (out_free),
		.op       (op)
	);

	gcl_datapath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.take      (take),
		.opnd      (opnd),
		.flags     (flags),
		.gcd_value (gcd_value),
		.lcm_value (lcm_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.gcd_value <= gcd_value;
			res_q.lcm_value <= lcm_value;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> opnd_stall)
		else $error("operand word taken while a pair is in flight");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.gcd_value != '0)
		else $error("zero gcd delivered");

	a_zero_case: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.lcm_value == '0)) |-> res.gcd_value == GCD_W'(1))
		else $error("zero lcm without unit gcd");

endmodule

// File: rtl/gcl_useq.sv
// ----------------------------------------------------------------------------
// gcl_useq
// Micro-sequencer: step counter, control store lookup and jump logic.
// ----------------------------------------------------------------------------
module gcl_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  gcl_pkg::gcl_flags_t flags,
	input  logic                in_take,
	input  logic                out_free,
	output gcl_pkg::gcl_uop_t   op
);
	import gcl_pkg::*;

	logic [UPC_W-1:0] pc_q;
	logic [UPC_W-1:0] pc_d;
	gcl_uword_t       uw;
	logic             jump;

	assign uw = gcl_rom(pc_q);
	assign op = uw.op;

	always_comb begin
		unique case (uw.cond)
			CND_ALWAYS:    jump = 1'b1;
			CND_IN_TAKE:   jump = in_take;
			CND_ANY_ZERO:  jump = flags.any_zero;
			CND_BOTH_EVEN: jump = flags.both_even;
			CND_NOT_EQUAL: jump = flags.not_equal;
			CND_CNT_MORE:  jump = flags.cnt_more;
			CND_OUT_FREE:  jump = out_free;
			default:       jump = 1'b1;
		endcase
	end

	always_comb begin
		priority if (jump) begin
			pc_d = uw.target;
		end else if (uw.hold) begin
			pc_d = pc_q;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= ST_LAST)
		else $error("step counter left the program");

endmodule

// File: rtl/gcl_datapath.sv
// ----------------------------------------------------------------------------
// gcl_datapath
// Working registers for binary gcd, restoring division and the final product.
// ----------------------------------------------------------------------------
module gcl_datapath #(
	parameter int OPERAND_WIDTH = gcl_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gcl_pkg::gcl_uop_t             op,
	input  logic                          take,
	input  gcl_pkg::gcl_in_t              opnd,
	output gcl_pkg::gcl_flags_t           flags,
	output logic [gcl_pkg::GCD_W-1:0]     gcd_value,
	output logic [gcl_pkg::LCM_W-1:0]     lcm_value
);
	import gcl_pkg::*;

	localparam int EW    = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;
	localparam int CNT_W = $clog2(EW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(EW - 1);

	logic [EW-1:0]    a_q, b_q, ob_q, g_q, q_q, r_q;
	logic [CNT_W-1:0] k_q;
	logic [2*EW-1:0]  p_q;

	logic [EW:0]      diff_ab, diff_ba;
	logic [EW:0]      rq, rdiff;

	assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba = {1'b0, b_q} - {1'b0, a_q};
	assign rq      = {r_q, q_q[EW-1]};
	assign rdiff   = rq - {1'b0, g_q};

	assign flags.any_zero  = (a_q == '0) || (b_q == '0);
	assign flags.both_even = !a_q[0] && !b_q[0];
	assign flags.not_equal = (a_q != b_q);
	assign flags.cnt_more  = (k_q != CNT_LAST);

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				if (take) begin
					a_q  <= opnd.first_operand[EW-1:0];
					q_q  <= opnd.first_operand[EW-1:0];
					b_q  <= opnd.second_operand[EW-1:0];
					ob_q <= opnd.second_operand[EW-1:0];
					k_q  <= '0;
				end
			end
			OP_STRIP: begin
				if (flags.both_even) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end
			end
			OP_REDUCE: begin
				priority if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q != b_q) begin
					if (!diff_ab[EW]) begin
						a_q <= {1'b0, diff_ab[EW-1:1]};
					end else begin
						b_q <= {1'b0, diff_ba[EW-1:1]};
					end
				end
			end
			OP_DIVINIT: begin
				g_q <= a_q << k_q;
				k_q <= '0;
				r_q <= '0;
			end
			OP_DIVSTEP: begin
				if (!rdiff[EW]) begin
					r_q <= rdiff[EW-1:0];
				end else begin
					r_q <= rq[EW-1:0];
				end
				q_q <= {q_q[EW-2:0], !rdiff[EW]};
				k_q <= k_q + 1'b1;
			end
			OP_MUL: begin
				p_q <= {{EW{1'b0}}, q_q} * {{EW{1'b0}}, ob_q};
			end
			OP_ZERO: begin
				g_q <= EW'(1);
				p_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign gcd_value = GCD_W'(g_q);
	assign lcm_value = LCM_W'(p_q);

	a_reduce_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_REDUCE |-> (a_q != '0) && (b_q != '0))
		else $error("gcd reduction reached a zero operand");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_DIVSTEP |-> r_q < g_q)
		else $error("division remainder not below divisor");

endmodule
